FILE: hw/rtl/rmq_pkg.sv
// Shared types for the rotation matrix to quaternion core.
// No dependencies; imported by the rmq cells, the core and the testbench.
`timescale 1ns / 1ps
package rmq_pkg;

  // Component taken as largest.
  typedef enum logic [1:0] {
    LG_X = 2'd0,
    LG_Y = 2'd1,
    LG_Z = 2'd2,
    LG_W = 2'd3
  } largest_t;

  // Per-word sideband that rides along the cell chains.
  typedef struct packed {
    logic       bad;
    largest_t   lg;
    logic [3:0] neg;
  } side_t;

endpackage

FILE: hw/rtl/rmq_sqrt_cell.sv
// One digit cell of the square-root chain: one root bit per cell.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_sqrt_cell #(
  parameter int GW = 16,
  parameter int TW = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  rmq_pkg::side_t        side_i,
  input  logic [2*GW-1:0]       rad_i,
  input  logic [GW:0]           rem_i,
  input  logic [GW-1:0]         root_i,
  input  logic [3:0][TW-1:0]    vec_i,
  output logic                  vld_o,
  output rmq_pkg::side_t        side_o,
  output logic [2*GW-1:0]       rad_o,
  output logic [GW:0]           rem_o,
  output logic [GW-1:0]         root_o,
  output logic [3:0][TW-1:0]    vec_o
);
  import rmq_pkg::*;

  logic              vld_r;
  side_t             side_r;
  logic [2*GW-1:0]   rad_r;
  logic [GW:0]       rem_r, rem_nxt;
  logic [GW-1:0]     root_r, root_nxt;
  logic [3:0][TW-1:0] vec_r;
  logic [GW+2:0]     cur, sub, diff;
  logic              ge;

  // Bring down the next radicand pair, try root*4+1.
  always_comb begin
    cur  = {rem_i, rad_i[2*GW-1 -: 2]};
    sub  = {1'b0, root_i, 2'b01};
    diff = cur - sub;
    ge   = (cur >= sub);
    if (ge) begin
      rem_nxt  = diff[GW:0];
      root_nxt = {root_i[GW-2:0], 1'b1};
    end else begin
      rem_nxt  = cur[GW:0];
      root_nxt = {root_i[GW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      rad_r  <= {rad_i[2*GW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      vec_r  <= vec_i;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign vec_o  = vec_r;

endmodule

FILE: hw/rtl/rmq_div_cell.sv
// One restoring-division cell, four lanes sharing one divisor.
// Numerator bits shift out the top while quotient bits shift in below.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
module rmq_div_cell #(
  parameter int GW = 16,
  parameter int NW = 34
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  rmq_pkg::side_t        side_i,
  input  logic [GW:0]           den_i,
  input  logic [3:0][GW:0]      rem_i,
  input  logic [3:0][NW-1:0]    nq_i,
  output logic                  vld_o,
  output rmq_pkg::side_t        side_o,
  output logic [GW:0]           den_o,
  output logic [3:0][GW:0]      rem_o,
  output logic [3:0][NW-1:0]    nq_o
);
  import rmq_pkg::*;

  logic               vld_r;
  side_t              side_r;
  logic [GW:0]        den_r;
  logic [3:0][GW:0]   rem_r, rem_nxt;
  logic [3:0][NW-1:0] nq_r, nq_nxt;
  logic [GW+1:0]      cur  [4];
  logic [GW+1:0]      diff [4];
  logic [3:0]         ge;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cur[k]     = {rem_i[k], nq_i[k][NW-1]};
      diff[k]    = cur[k] - {1'b0, den_i};
      ge[k]      = (cur[k] >= {1'b0, den_i});
      rem_nxt[k] = ge[k] ? diff[k][GW:0] : cur[k][GW:0];
      nq_nxt[k]  = {nq_i[k][NW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      den_r  <= den_i;
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign den_o  = den_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;

endmodule

FILE: hw/rtl/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to unit quaternion, largest-component method.
// Top level; uses rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
//
//  channel | dir | tdata (low bit up)                  | tuser
//  --------+-----+-------------------------------------+--------------------
//  in_     | in  | r00 r01 r02 r10 r11 r12 r20 r21 r22 | -
//  out_    | out | qx qy qz qw                         | largest, bad_input
//
// One word in per cycle, one word out per cycle, sustained while the output is not stalled.
// The chain is the entry register, GW root cells, NW divider cells and the output
// register; with the default Q2.14 in 16 bits GW is 16 and NW is 34.
// Reset (synchronous, rst_n low) clears every valid bit; payload is not reset.
// A stall at the output freezes the whole chain; in_tready follows it in the
// same cycle, so nothing is dropped or repeated.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = 14,
  parameter int WORD_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // r00,r01,r02,r10,r11,r12,r20,r21,r22 from bit 0, WORD_BITS each, zero pad
  input  logic [((9*WORD_BITS+7)/8)*8-1:0]        in_tdata,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // qx,qy,qz,qw from bit 0, WORD_BITS each, zero pad
  output logic [((4*WORD_BITS+7)/8)*8-1:0]        out_tdata,
  // largest [1:0], bad_input [2]
  output logic [2:0]                              out_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready
);
  import rmq_pkg::*;

  // Internal widths: TW holds any trace term or off-diagonal sum.
  localparam int TW     = ((WORD_BITS > FRAC_BITS + 1) ? WORD_BITS : FRAC_BITS + 1) + 3;
  localparam int SW     = TW - 1 + FRAC_BITS;    // radicand T << F
  localparam int GW     = (SW + 1) / 2;          // root width
  localparam int NW     = TW + FRAC_BITS + 1;    // dividend / quotient width
  localparam int OUT_DW = ((4 * WORD_BITS + 7) / 8) * 8;
  localparam logic signed [TW-1:0] ONE_C = TW'(1) << FRAC_BITS;
  localparam logic [NW-1:0] LIM_C = NW'(1) << (WORD_BITS - 1);

  logic adv;

  // ---- entry stage: branch select, trace term, off-diagonal terms ----
  logic signed [TW-1:0] e [9];
  logic signed [TW-1:0] t_c;
  logic signed [TW-1:0] v_c [4];
  largest_t             lg_c;
  logic                 bad_c;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = {{(TW-WORD_BITS){in_tdata[i*WORD_BITS+WORD_BITS-1]}},
              in_tdata[i*WORD_BITS +: WORD_BITS]};
    end
    // e: 0 r00, 1 r01, 2 r02, 3 r10, 4 r11, 5 r12, 6 r20, 7 r21, 8 r22
    if (e[8] < 0) begin
      if (e[0] > e[4]) begin
        lg_c   = LG_X;
        t_c    = ONE_C + e[0] - e[4] - e[8];
        v_c[0] = t_c;           v_c[1] = e[3] + e[1];
        v_c[2] = e[6] + e[2];   v_c[3] = e[7] - e[5];
      end else begin
        lg_c   = LG_Y;
        t_c    = ONE_C - e[0] + e[4] - e[8];
        v_c[0] = e[3] + e[1];   v_c[1] = t_c;
        v_c[2] = e[7] + e[5];   v_c[3] = e[2] - e[6];
      end
    end else begin
      if (e[0] < -e[4]) begin
        lg_c   = LG_Z;
        t_c    = ONE_C - e[0] - e[4] + e[8];
        v_c[0] = e[6] + e[2];   v_c[1] = e[7] + e[5];
        v_c[2] = t_c;           v_c[3] = e[3] - e[1];
      end else begin
        lg_c   = LG_W;
        t_c    = ONE_C + e[0] + e[4] + e[8];
        v_c[0] = e[7] - e[5];   v_c[1] = e[2] - e[6];
        v_c[2] = e[3] - e[1];   v_c[3] = t_c;
      end
    end
    bad_c = t_c[TW-1] || (t_c == '0);
  end

  // ---- root chain ----
  logic               s_vld  [GW+1];
  side_t              s_side [GW+1];
  logic [2*GW-1:0]    s_rad  [GW+1];
  logic [GW:0]        s_rem  [GW+1];
  logic [GW-1:0]      s_root [GW+1];
  logic [3:0][TW-1:0] s_vec  [GW+1];

  logic               in_vld_r;
  side_t              in_side_r;
  logic [2*GW-1:0]    in_rad_r;
  logic [3:0][TW-1:0] in_vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_side_r.bad <= bad_c;
      in_side_r.lg  <= lg_c;
      for (int k = 0; k < 4; k++) begin
        in_side_r.neg[k] <= v_c[k][TW-1];
        in_vec_r[k]      <= v_c[k];
      end
      // a non-positive term gives a zero radicand; the result is forced later
      in_rad_r <= bad_c ? '0 : (2*GW)'({t_c[TW-2:0], {FRAC_BITS{1'b0}}});
    end
  end

  assign s_vld[0]  = in_vld_r;
  assign s_side[0] = in_side_r;
  assign s_rad[0]  = in_rad_r;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_vec[0]  = in_vec_r;

  for (genvar g = 0; g < GW; g++) begin : g_sqrt
    rmq_sqrt_cell #(.GW(GW), .TW(TW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (s_vld[g]),
      .side_i (s_side[g]),
      .rad_i  (s_rad[g]),
      .rem_i  (s_rem[g]),
      .root_i (s_root[g]),
      .vec_i  (s_vec[g]),
      .vld_o  (s_vld[g+1]),
      .side_o (s_side[g+1]),
      .rad_o  (s_rad[g+1]),
      .rem_o  (s_rem[g+1]),
      .root_o (s_root[g+1]),
      .vec_o  (s_vec[g+1])
    );
  end

  // ---- divider chain: n = (|v| << F + G) / (2G) ----
  logic               d_vld  [NW+1];
  side_t              d_side [NW+1];
  logic [GW:0]        d_den  [NW+1];
  logic [3:0][GW:0]   d_rem  [NW+1];
  logic [3:0][NW-1:0] d_nq   [NW+1];
  logic [GW-1:0]      root_fix;
  logic [TW-1:0]      mag [4];

  always_comb begin
    // zero root only when the word is flagged bad
    root_fix = (s_root[GW] == '0) ? GW'(1) : s_root[GW];
    for (int k = 0; k < 4; k++) begin
      mag[k]      = s_vec[GW][k][TW-1] ? -s_vec[GW][k] : s_vec[GW][k];
      d_nq[0][k]  = NW'({mag[k], {FRAC_BITS{1'b0}}}) + NW'(root_fix);
      d_rem[0][k] = '0;
    end
  end

  assign d_vld[0]  = s_vld[GW];
  assign d_side[0] = s_side[GW];
  assign d_den[0]  = {root_fix, 1'b0};

  for (genvar g = 0; g < NW; g++) begin : g_div
    rmq_div_cell #(.GW(GW), .NW(NW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (d_vld[g]),
      .side_i (d_side[g]),
      .den_i  (d_den[g]),
      .rem_i  (d_rem[g]),
      .nq_i   (d_nq[g]),
      .vld_o  (d_vld[g+1]),
      .side_o (d_side[g+1]),
      .den_o  (d_den[g+1]),
      .rem_o  (d_rem[g+1]),
      .nq_o   (d_nq[g+1])
    );
  end

  // ---- saturate, sign and output register ----
  logic [WORD_BITS-1:0] q_nxt [4];
  logic [NW-1:0]        sat  [4];
  logic [NW-1:0]        negv [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (d_side[NW].neg[k]) begin
        sat[k] = (d_nq[NW][k] > LIM_C) ? LIM_C : d_nq[NW][k];
      end else begin
        sat[k] = (d_nq[NW][k] > LIM_C - NW'(1)) ? LIM_C - NW'(1) : d_nq[NW][k];
      end
      negv[k] = NW'(0) - sat[k];
      if (d_side[NW].bad) begin
        q_nxt[k] = '0;
      end else if (d_side[NW].neg[k]) begin
        q_nxt[k] = negv[k][WORD_BITS-1:0];
      end else begin
        q_nxt[k] = sat[k][WORD_BITS-1:0];
      end
    end
  end

  logic                 out_vld_r;
  logic [WORD_BITS-1:0] q_r [4];
  largest_t             lg_r;
  logic                 bad_r;

  assign adv = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        q_r[k] <= q_nxt[k];
      end
      lg_r  <= d_side[NW].lg;
      bad_r <= d_side[NW].bad;
    end
  end

  assign in_tready  = adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DW'({q_r[3], q_r[2], q_r[1], q_r[0]});
  assign out_tuser  = {bad_r, lg_r};

endmodule

FILE: hw/rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion core.
// Bound to rotation_matrix_to_quaternion_core below.
`timescale 1ns / 1ps
module rmq_checker #(
  parameter int WORD_BITS = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((4*WORD_BITS+7)/8)*8-1:0]    out_tdata,
  input logic [2:0]                          out_tuser
);

  // a flagged word carries all-zero components
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == '0)
    else $error("bad word with non-zero components");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed under stall");

  // reset empties the chain
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("word left valid after reset");

  // input side only stalls when the output is blocked
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready out of step with output stall");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(.WORD_BITS(WORD_BITS)) u_rmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/rotation_matrix_to_quaternion_core_tb.sv
// Testbench for rotation_matrix_to_quaternion_core: directed table then random matrices,
// each word checked against a local fixed-point quaternion predictor.
// Depends on rmq_pkg and the core RTL only.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core_tb;
  import rmq_pkg::*;

  localparam int FB = 14;
  localparam int WB = 16;
  localparam int LATENCY = 52;
  localparam int N_RANDOM = 1700;

  typedef logic signed [WB-1:0] ent_t;
  typedef ent_t mat_t [9];
  typedef struct packed {
    logic       bad;
    largest_t   lg;
    logic [15:0] qw, qz, qy, qx;
  } quat_t;
  typedef struct {
    mat_t  m;
    logic  has_exp;
    quat_t exp_q;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [143:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;

  quat_t quat_q[$];
  int errors = 0;

  rotation_matrix_to_quaternion_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bitwise integer square root, floor.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale one component by 0.5/sqrt(t), round half away, saturate.
  function automatic logic [15:0] scale_sat(longint v, longint unsigned g);
    longint unsigned mag, n;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    n = ((mag << FB) + g) / (g * 2);
    if (v < 0) begin
      if (n > 32768) n = 32768;
      return 16'(-n);
    end
    if (n > 32767) n = 32767;
    return 16'(n);
  endfunction

  function automatic quat_t quat_of(mat_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, t;
    longint v[4];
    longint unsigned g;
    quat_t q;
    a00 = m[0]; a01 = m[1]; a02 = m[2];
    a10 = m[3]; a11 = m[4]; a12 = m[5];
    a20 = m[6]; a21 = m[7]; a22 = m[8];
    if (a22 < 0) begin
      if (a00 > a11) begin
        q.lg = LG_X; t = (1 << FB) + a00 - a11 - a22;
        v = '{t, a10 + a01, a20 + a02, a21 - a12};
      end else begin
        q.lg = LG_Y; t = (1 << FB) - a00 + a11 - a22;
        v = '{a10 + a01, t, a21 + a12, a02 - a20};
      end
    end else if (a00 < -a11) begin
      q.lg = LG_Z; t = (1 << FB) - a00 - a11 + a22;
      v = '{a20 + a02, a21 + a12, t, a10 - a01};
    end else begin
      q.lg = LG_W; t = (1 << FB) + a00 + a11 + a22;
      v = '{a21 - a12, a02 - a20, a10 - a01, t};
    end
    if (t <= 0) begin
      q.bad = 1'b1;
      q.qx = '0; q.qy = '0; q.qz = '0; q.qw = '0;
    end else begin
      g = root_floor(longint'(t) << FB);
      if (g == 0) g = 1;
      q.bad = 1'b0;
      q.qx = scale_sat(v[0], g); q.qy = scale_sat(v[1], g);
      q.qz = scale_sat(v[2], g); q.qw = scale_sat(v[3], g);
    end
    return q;
  endfunction

  function automatic mat_t rand_mat();
    mat_t m;
    int sel;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (sel < 6) m[i] = ent_t'($signed($urandom_range(0, 32768)) - 16384);
      else if (sel < 9) m[i] = ent_t'($urandom);
      else m[i] = $urandom_range(0, 1) ? ent_t'(16'h7fff) : ent_t'(16'h8000);
    end
    // near-identity style rotations hit each branch with positive trace
    if (sel == 0) begin
      m[0] = -m[0]; m[4] = -m[4];
    end
    return m;
  endfunction

  // Idle for the given gap, then hold the word until it is taken; valid stays
  // high afterwards so a following word can go out with no gap.
  task automatic send_word(mat_t m, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    for (int i = 0; i < 9; i++) in_tdata[i*WB +: WB] <= m[i];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quat_q.push_back(quat_of(m));
  endtask

  task automatic check_word(quat_t got, quat_t exp_q);
    if (got !== exp_q) begin
      errors++;
      $display("%0t mismatch: expected qx=%h qy=%h qz=%h qw=%h lg=%0d bad=%b",
               $time, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.lg, exp_q.bad);
      $display("%0t           actual   qx=%h qy=%h qz=%h qw=%h lg=%0d bad=%b",
               $time, got.qx, got.qy, got.qz, got.qw, got.lg, got.bad);
    end
  endtask

  // Receiver: random stall per word; stretches with no stall too.
  initial begin
    quat_t got;
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = {out_tuser[2], largest_t'(out_tuser[1:0]), out_tdata};
      if (quat_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, actual %h/%h",
                 $time, out_tdata, out_tuser);
      end else begin
        check_word(got, quat_q.pop_front());
      end
    end
  end

  // Directed table: identity, half turns, extremes, branch boundaries.
  vec_t dir_tab[$];

  function automatic vec_t row(ent_t a0, ent_t a1, ent_t a2, ent_t a3, ent_t a4,
                               ent_t a5, ent_t a6, ent_t a7, ent_t a8);
    vec_t r;
    r.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    r.has_exp = 1'b0;
    return r;
  endfunction

  initial begin
    vec_t r;
    quat_t e;
    // identity: w branch, qw = 1.0
    r = row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    r.has_exp = 1; e = '0; e.lg = LG_W; e.qw = 16'd16384; r.exp_q = e;
    dir_tab.push_back(r);
    // half turn about x: x branch
    r = row(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    r.has_exp = 1; e = '0; e.lg = LG_X; e.qx = 16'd16384; r.exp_q = e;
    dir_tab.push_back(r);
    // half turn about y
    r = row(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
    r.has_exp = 1; e = '0; e.lg = LG_Y; e.qy = 16'd16384; r.exp_q = e;
    dir_tab.push_back(r);
    // half turn about z
    r = row(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
    r.has_exp = 1; e = '0; e.lg = LG_Z; e.qz = 16'd16384; r.exp_q = e;
    dir_tab.push_back(r);
    // r00 equal -r11 with zero r22: stays in the w branch
    r = row(-16384, 0, 0, 0, 16384, 0, 0, 0, 0);
    r.m[4] = 0; r.m[0] = 0; r.m[8] = 0; r.m[0] = -16384; r.m[4] = 16384;
    dir_tab.push_back(r);
    // r00 just below -r11: z branch at the word extremes
    r = row(0, 0, 0, 0, 0, 0, 0, 0, 16'sh8000);
    r.m[8] = 0; r.m[0] = -32768; r.m[4] = 32767; r.m[8] = 0;
    dir_tab.push_back(r);
    // lone negative r00: z branch, qz = sqrt(0.5)
    r = row(-16384, 0, 0, 0, 0, 0, 0, 0, 0);
    r.has_exp = 1; e = '0; e.lg = LG_Z; e.qz = 16'd11585; r.exp_q = e;
    dir_tab.push_back(r);
    // all zero: w branch, t = 1.0
    r = row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    r.has_exp = 1; e = '0; e.lg = LG_W; e.qw = 16'd8192; r.exp_q = e;
    dir_tab.push_back(r);
    // all max, all min, mixed extremes (saturation)
    dir_tab.push_back(row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    dir_tab.push_back(row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          -32768));
    dir_tab.push_back(row(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                          -1));
    dir_tab.push_back(row(32767, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
                          -32768));
    dir_tab.push_back(row(32767, 32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768));
    // trace near -1.0, large off-diagonals: both rows fall in the z branch
    dir_tab.push_back(row(-16383, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0));
    dir_tab.push_back(row(-16384, 32767, 32767, 32767, -1, 32767, 32767, 32767, 1));
    // r00 equal r11 ties, r00 equal -r11
    dir_tab.push_back(row(5000, 100, -200, 300, 5000, -400, 500, -600, -1));
    dir_tab.push_back(row(-5000, 100, -200, 300, 5000, -400, 500, -600, 0));
    // 90 degrees about z
    dir_tab.push_back(row(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
  end

  initial begin
    quat_t e;
    int wait_cnt;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_exp) begin
        e = quat_of(dir_tab[i].m);
        if (e !== dir_tab[i].exp_q) begin
          errors++;
          $display("%0t table row %0d: expected %h, actual predictor %h",
                   $time, i, dir_tab[i].exp_q, e);
        end
      end
      send_word(dir_tab[i].m, $urandom_range(0, 9));
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      // one hold-off until the pipeline drains
      if (n == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (quat_q.size() != 0) @(posedge clk);
      end
      if ((n / 100) % 3 == 2) begin
        // back-to-back stretch: no sender gap
        send_word(rand_mat(), 0);
      end else begin
        send_word(rand_mat(), $urandom_range(0, 9));
      end
    end
    in_tvalid <= 1'b0;
    wait_cnt = 0;
    while (quat_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && quat_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (quat_q.size() != 0)
        $display("%0t %0d words never arrived", $time, quat_q.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
